[rtl/iee_pkg.sv]
// Package for the infix expression evaluator: payload structs, operator codes,
// controller/datapath command and status structs. No dependencies.
package iee_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned MAX_CHARS_DEF   = 64;
  localparam int unsigned DATA_W          = 32;

  localparam logic [2:0] OP_LPAREN = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } out_item_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic       clear;       // reset all expression state
    logic       digit;       // fold digit into literal
    logic [3:0] digit_val;
    logic       end_lit;     // push literal if one is open
    logic       push_op;     // push operator code
    logic [2:0] push_code;
    logic       pop_op;      // drop top operator (matching paren)
    logic       red_start;   // pop operator and two operands, start arithmetic
    logic       set_err;
  } dp_cmd_t;

  typedef struct packed {
    logic       err;
    logic       op_empty;
    logic [2:0] op_top;
    logic       opnd_one;    // exactly one operand on the stack
    logic       busy;        // arithmetic/push in progress
    logic       lit_open;
  } dp_stat_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    if (op == OP_LPAREN) return 2'd3;
    if (op == OP_MUL || op == OP_DIV) return 2'd2;
    return 2'd1;
  endfunction

endpackage

[rtl/iee_divider.sv]
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on iee_pkg.
module iee_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import iee_pkg::*;

  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, run_r, run_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[30:0], quo_r[31]};
    trial    = {1'b0, shifted} - {1'b0, dvs_r};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_nxt = divisor[31] ? (32'd0 - divisor) : divisor;
      neg_nxt = dividend[31] ^ divisor[31];
      cnt_nxt = 6'd32;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;
endmodule

[rtl/iee_datapath.sv]
// Datapath: operand and operator stacks, literal accumulator, arithmetic.
// Depends on iee_pkg and iee_divider.
module iee_datapath #(
  parameter int unsigned STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iee_pkg::dp_cmd_t  cmd,
  output iee_pkg::dp_stat_t stat,
  output logic [31:0]       result
);
  import iee_pkg::*;

  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // Arithmetic sequencer phases.
  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_RD1  = 3'd1;
  localparam logic [2:0] A_RD2  = 3'd2;
  localparam logic [2:0] A_EXEC = 3'd3;
  localparam logic [2:0] A_DIVW = 3'd4;
  localparam logic [2:0] A_PUSH = 3'd5;

  logic [31:0] opnd_mem [STACK_DEPTH];
  logic [2:0]  optr_mem [STACK_DEPTH];

  logic [CW-1:0] ocnt_r, ocnt_nxt, pcnt_r, pcnt_nxt;
  logic [31:0]   lit_r, lit_nxt, lhs_r, lhs_nxt, rhs_r, rhs_nxt, res_r, res_nxt;
  logic [31:0]   rd_r;
  logic          inlit_r, inlit_nxt, err_r, err_nxt;
  logic [2:0]    aop_r, aop_nxt, ast_r, ast_nxt;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;
  logic          optr_we;
  logic [IW-1:0] optr_wa;
  logic [2:0]    optr_wd, optr_top;
  logic          div_start, div_done;
  logic [31:0]   div_q;

  iee_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(lhs_r), .divisor(rhs_r), .done(div_done), .quotient(div_q)
  );

  // Top of operator stack lives in a small register file read at one place.
  assign optr_top = (pcnt_r == '0) ? OP_LPAREN : optr_mem[IW'(pcnt_r - CW'(1))];

  always_comb begin
    ocnt_nxt  = ocnt_r;
    pcnt_nxt  = pcnt_r;
    lit_nxt   = lit_r;
    inlit_nxt = inlit_r;
    err_nxt   = err_r;
    lhs_nxt   = lhs_r;
    rhs_nxt   = rhs_r;
    res_nxt   = res_r;
    aop_nxt   = aop_r;
    ast_nxt   = ast_r;
    wr_en     = 1'b0;
    wr_addr   = IW'(ocnt_r);
    wr_data   = lit_r;
    rd_addr   = IW'(ocnt_r - CW'(1));
    optr_we   = 1'b0;
    optr_wa   = IW'(pcnt_r);
    optr_wd   = cmd.push_code;

    if (cmd.clear) begin
      ocnt_nxt  = '0;
      pcnt_nxt  = '0;
      lit_nxt   = '0;
      inlit_nxt = 1'b0;
      err_nxt   = 1'b0;
      ast_nxt   = A_IDLE;
    end else begin
      if (cmd.set_err) err_nxt = 1'b1;
      if (cmd.digit) begin
        lit_nxt   = (inlit_r ? ((lit_r << 3) + (lit_r << 1)) : 32'd0)
                    + {28'd0, cmd.digit_val};
        inlit_nxt = 1'b1;
      end
      if (cmd.end_lit && inlit_r) begin
        inlit_nxt = 1'b0;
        lit_nxt   = '0;
        if (ocnt_r == DEPTH_C) err_nxt = 1'b1;
        else begin
          wr_en    = 1'b1;
          ocnt_nxt = ocnt_r + CW'(1);
        end
      end
      if (cmd.push_op) begin
        if (pcnt_r == DEPTH_C) err_nxt = 1'b1;
        else begin
          optr_we  = 1'b1;
          pcnt_nxt = pcnt_r + CW'(1);
        end
      end
      if (cmd.pop_op) pcnt_nxt = pcnt_r - CW'(1);
      if (cmd.red_start) begin
        if (pcnt_r == '0) err_nxt = 1'b1;
        else begin
          pcnt_nxt = pcnt_r - CW'(1);
          aop_nxt  = optr_top;
          if (ocnt_r < CW'(2)) err_nxt = 1'b1;
          else ast_nxt = A_RD1;
        end
      end

      unique case (ast_r)
        A_IDLE: ;
        A_RD1: begin
          // The top operand read in the start cycle is the right-hand side.
          rhs_nxt = rd_r;
          rd_addr = IW'(ocnt_r - CW'(2));
          ast_nxt = A_RD2;
        end
        A_RD2: begin
          rd_addr  = IW'(ocnt_r - CW'(2));
          ocnt_nxt = ocnt_r - CW'(2);
          ast_nxt  = A_EXEC;
        end
        A_EXEC: begin
          lhs_nxt = rd_r;
          ast_nxt = A_PUSH;
          unique case (aop_r)
            OP_ADD: res_nxt = rd_r + rhs_r;
            OP_SUB: res_nxt = rd_r - rhs_r;
            OP_MUL: res_nxt = rd_r * rhs_r;
            OP_DIV: begin
              if (rhs_r == '0) begin
                err_nxt = 1'b1;
                ast_nxt = A_IDLE;
              end else ast_nxt = A_DIVW;
            end
            default: begin
              err_nxt = 1'b1;
              ast_nxt = A_IDLE;
            end
          endcase
        end
        A_DIVW: begin
          if (div_done) begin
            res_nxt = div_q;
            ast_nxt = A_PUSH;
          end
        end
        A_PUSH: begin
          wr_en    = 1'b1;
          wr_data  = res_r;
          ocnt_nxt = ocnt_r + CW'(1);
          ast_nxt  = A_IDLE;
        end
        default: ast_nxt = A_IDLE;
      endcase
    end
  end

  // Divider start is registered, so it rises in the same cycle that lhs/rhs hold the operands.
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else div_go_r <= (ast_r == A_EXEC) && (aop_r == OP_DIV) && (rhs_r != '0)
                     && !cmd.clear;
  end
  assign div_start = div_go_r;

  always_ff @(posedge clk) begin
    if (wr_en) opnd_mem[wr_addr] <= wr_data;
    rd_r <= opnd_mem[rd_addr];
    if (optr_we) optr_mem[optr_wa] <= optr_wd;
  end

  always_ff @(posedge clk) begin
    lit_r <= lit_nxt;
    lhs_r <= lhs_nxt;
    rhs_r <= rhs_nxt;
    res_r <= res_nxt;
    aop_r <= aop_nxt;
    if (!rst_n) begin
      ocnt_r  <= '0;
      pcnt_r  <= '0;
      inlit_r <= 1'b0;
      err_r   <= 1'b0;
      ast_r   <= A_IDLE;
    end else begin
      ocnt_r  <= ocnt_nxt;
      pcnt_r  <= pcnt_nxt;
      inlit_r <= inlit_nxt;
      err_r   <= err_nxt;
      ast_r   <= ast_nxt;
    end
  end

  // With a single operand left, the read port already points at entry zero.
  assign result        = rd_r;
  assign stat.err      = err_r;
  assign stat.op_empty = (pcnt_r == '0);
  assign stat.op_top   = optr_top;
  assign stat.opnd_one = (ocnt_r == CW'(1));
  assign stat.busy     = (ast_r != A_IDLE);
  assign stat.lit_open = inlit_r;
endmodule

[rtl/iee_controller.sv]
// Controller state machine: decodes characters and sequences reductions.
// Depends on iee_pkg.
module iee_controller #(
  parameter int unsigned MAX_CHARS = iee_pkg::MAX_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iee_pkg::in_item_t  in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output iee_pkg::out_item_t out_data,
  output iee_pkg::dp_cmd_t   cmd,
  input  iee_pkg::dp_stat_t  stat,
  input  logic [31:0]        result
);
  import iee_pkg::*;

  localparam int unsigned NW = $clog2(MAX_CHARS);
  localparam logic [NW-1:0] LIMIT_C = NW'(MAX_CHARS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHAR  = 3'd1;  // fold a digit, or end literal, then classify
  localparam logic [2:0] S_LOOP  = 3'd2;  // reduce loop for operator or ')', push for '('
  localparam logic [2:0] S_WAIT  = 3'd3;  // wait for reduction to finish
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FWAIT = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;  // read slot settles
  localparam logic [2:0] S_EMIT2 = 3'd7;

  logic [2:0]    st_r, st_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          last_r, last_nxt, take_r, take_nxt;
  logic          ov_r, ov_nxt;
  out_item_t     od_r, od_nxt;
  logic          is_op, is_close, stop;
  logic [2:0]    op_code;
  logic [1:0]    p_in;

  always_comb begin
    is_op   = 1'b1;
    op_code = OP_ADD;
    case (ch_r)
      CH_ADD: op_code = OP_ADD;
      CH_SUB: op_code = OP_SUB;
      CH_MUL: op_code = OP_MUL;
      CH_DIV: op_code = OP_DIV;
      default: is_op = 1'b0;
    endcase
    is_close = (ch_r == CH_RPAREN);
    p_in     = prec(op_code);
    // Reduction loop ends at empty stack, '(' or lower precedence.
    stop = stat.op_empty || (stat.op_top == OP_LPAREN) ||
           (!is_close && (prec(stat.op_top) < p_in));
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    ch_nxt   = ch_r;
    last_nxt = last_r;
    take_nxt = take_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    cmd      = '0;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt   = in_data.char_code;
          last_nxt = in_data.end_of_expr;
          take_nxt = (cnt_r < LIMIT_C) && !stat.err;
          if (cnt_r < LIMIT_C) cnt_nxt = cnt_r + NW'(1);
          st_nxt   = S_CHAR;
        end
      end
      S_CHAR: begin
        st_nxt = last_r ? S_FLUSH : S_IDLE;
        if (take_r) begin
          if (ch_r >= CH_ZERO && ch_r <= CH_NINE) begin
            cmd.digit     = 1'b1;
            cmd.digit_val = 4'(ch_r - CH_ZERO);
          end else begin
            cmd.end_lit = 1'b1;
            if (ch_r == CH_LPAREN) begin
              st_nxt = S_WAIT;
            end else if (is_op || is_close) begin
              st_nxt = S_WAIT;
            end else cmd.set_err = 1'b1;
          end
        end
      end
      S_WAIT: begin
        // Settle after any stack change and wait until the datapath is idle before deciding.
        if (!stat.busy) st_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (stat.err) st_nxt = last_r ? S_FLUSH : S_IDLE;
        else if (ch_r == CH_LPAREN) begin
          cmd.push_op   = 1'b1;
          cmd.push_code = OP_LPAREN;
          st_nxt = last_r ? S_FLUSH : S_IDLE;
        end else if (!stop) begin
          cmd.red_start = 1'b1;
          st_nxt = S_WAIT;
        end else if (is_close) begin
          if (stat.op_empty) cmd.set_err = 1'b1;
          else cmd.pop_op = 1'b1;
          st_nxt = last_r ? S_FLUSH : S_IDLE;
        end else begin
          cmd.push_op   = 1'b1;
          cmd.push_code = op_code;
          st_nxt = last_r ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!stat.err) cmd.end_lit = 1'b1;
        st_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (!stat.busy) begin
          if (stat.err || stat.op_empty) st_nxt = S_EMIT;
          else if (stat.op_top == OP_LPAREN) begin
            cmd.set_err = 1'b1;
            st_nxt = S_EMIT;
          end else cmd.red_start = 1'b1;
        end
      end
      S_EMIT: st_nxt = S_EMIT2;
      S_EMIT2: begin
        if (!ov_r || out_ready) begin
          od_nxt.error = stat.err || !stat.opnd_one;
          od_nxt.value = od_nxt.error ? 32'sd0 : $signed(result);
          ov_nxt   = 1'b1;
          cmd.clear = 1'b1;
          cnt_nxt  = '0;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
    take_r <= take_nxt;
    od_r   <= od_nxt;
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

[rtl/infix_expression_evaluator.sv]
// Top level of the infix expression evaluator: controller plus datapath.
// Depends on iee_pkg, iee_controller, iee_datapath (and iee_divider below it).
//
//  Channel | Direction | Payload                      | Handshake
//  in_     | input     | in_item_t {char_code, eoe}   | in_valid / in_ready
//  out_    | output    | out_item_t {value, error}    | out_valid / out_ready
//
// A digit or an unknown character passes through the character state only. An
// operator or parenthesis also waits for the datapath and runs the reduce loop
// once for every reduction it causes, and a division waits on the bit-serial
// divider, which sets the worst case. The end-of-expression beat flushes the
// operator stack one reduction at a time and then reads the result from the
// operand stack.
// Reset is synchronous and active low and clears control state only; stack
// contents are undefined until written. A held result beat does not stop the
// block taking the next expression; only a second result waits for it.
module infix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_CHARS   = iee_pkg::MAX_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iee_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iee_pkg::out_item_t out_data
);
  import iee_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] result;

  // Controller: character decode, reduction sequencing and result register.
  iee_controller #(.MAX_CHARS(MAX_CHARS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data),
    .cmd(cmd), .stat(stat), .result(result)
  );

  // Datapath: both stacks, the literal builder and the arithmetic unit.
  iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .result(result)
  );
endmodule

[tb/sv/infix_expression_evaluator_tb.sv]
// Self-checking testbench for the infix expression evaluator: character beats in,
// checked result beats out. Depends on iee_pkg and the infix_expression_evaluator RTL.
module infix_expression_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iee_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned MAXC  = MAX_CHARS_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  infix_expression_evaluator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character beats waiting to be driven, and results still owed by the block.
  in_item_t  char_queue[$];
  out_item_t owed_results[$];
  int        mismatches = 0;
  bit        stimulus_done = 1'b0;

  // Idling levels in percent, switched by the stimulus phases.
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 83;
  int unsigned hold_off_cycles = 0;   // receiver long stall, counted down below
  bit          send_pause = 1'b0;     // sender waits until nothing is owed

  // ---------------------------------------------------------------------------
  // Evaluator state, mirroring the two-stack scheme.
  // ---------------------------------------------------------------------------
  logic [31:0] val_stack[DEPTH];
  int unsigned val_cnt;
  logic [2:0]  op_stack[DEPTH];
  int unsigned op_cnt;
  logic [31:0] lit_acc;
  bit          lit_open, failed;
  int unsigned chars_taken;

  function automatic int unsigned op_rank(logic [2:0] op);
    if (op == OP_LPAREN) return 3;
    if (op == OP_MUL || op == OP_DIV) return 2;
    return 1;
  endfunction

  task automatic clear_expr();
    val_cnt = 0; op_cnt = 0; lit_acc = '0; lit_open = 0; failed = 0; chars_taken = 0;
  endtask

  task automatic push_val(logic [31:0] v);
    if (val_cnt >= DEPTH) failed = 1;
    else begin
      val_stack[val_cnt] = v;
      val_cnt++;
    end
  endtask

  task automatic push_op(logic [2:0] op);
    if (op_cnt >= DEPTH) failed = 1;
    else begin
      op_stack[op_cnt] = op;
      op_cnt++;
    end
  endtask

  // Pops one operator and applies it to the two topmost operands.
  task automatic apply_top();
    logic [2:0]  op;
    logic [31:0] a, b, ma, mb, q;
    if (op_cnt == 0) begin
      failed = 1;
      return;
    end
    op_cnt--;
    op = op_stack[op_cnt];
    if (val_cnt < 2) begin
      failed = 1;
      return;
    end
    b = val_stack[val_cnt-1];
    a = val_stack[val_cnt-2];
    val_cnt -= 2;
    case (op)
      OP_ADD: push_val(a + b);
      OP_SUB: push_val(a - b);
      OP_MUL: push_val(a * b);
      OP_DIV: begin
        if (b == 0) begin
          failed = 1;
          return;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        push_val((a[31] != b[31]) ? -q : q);
      end
      default: failed = 1;
    endcase
  endtask

  task automatic close_literal();
    if (lit_open) begin
      push_val(lit_acc);
      lit_acc = '0;
      lit_open = 0;
    end
  endtask

  task automatic take_char(logic [7:0] c);
    logic [2:0] op;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      lit_acc = lit_open ? lit_acc * 32'd10 + 32'(c - CH_ZERO) : 32'(c - CH_ZERO);
      lit_open = 1;
      return;
    end
    close_literal();
    if (failed) return;
    if (c == CH_LPAREN) begin
      push_op(OP_LPAREN);
      return;
    end
    if (c == CH_RPAREN) begin
      while (!failed && op_cnt > 0 && op_stack[op_cnt-1] != OP_LPAREN) apply_top();
      if (failed) return;
      if (op_cnt == 0) failed = 1;
      else op_cnt--;
      return;
    end
    case (c)
      CH_ADD: op = OP_ADD;
      CH_SUB: op = OP_SUB;
      CH_MUL: op = OP_MUL;
      CH_DIV: op = OP_DIV;
      default: begin
        failed = 1;
        return;
      end
    endcase
    while (!failed && op_cnt > 0 && op_stack[op_cnt-1] != OP_LPAREN &&
           op_rank(op_stack[op_cnt-1]) >= op_rank(op)) apply_top();
    if (!failed) push_op(op);
  endtask

  // Advances the evaluator by one accepted beat and queues the result, if any.
  task automatic evaluate_beat(in_item_t beat);
    out_item_t r;
    if (chars_taken < MAXC - 1) begin
      chars_taken++;
      if (!failed) take_char(beat.char_code);
    end
    if (!beat.end_of_expr) return;
    if (!failed) close_literal();
    while (!failed && op_cnt > 0) begin
      if (op_stack[op_cnt-1] == OP_LPAREN) failed = 1;
      else apply_top();
    end
    if (!failed && val_cnt != 1) failed = 1;
    r.error = failed;
    r.value = failed ? 32'sd0 : val_stack[0];
    owed_results.push_back(r);
    clear_expr();
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the queued beats, idling at random between them.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        evaluate_beat(in_data);
        void'(char_queue.pop_front());
      end
      // Valid stays up until the beat is taken; only decide afresh afterwards.
      if (!in_valid || in_ready) begin
        if (char_queue.size() > (in_valid && in_ready ? 0 : 0) &&
            !send_pause && $urandom_range(99) >= send_idle_pct &&
            char_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= char_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall control.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) report_mismatch("result beat with none expected");
        else begin
          if (out_data.value !== owed_results[0].value)
            report_mismatch($sformatf("value %0d, expected %0d",
                                      out_data.value, owed_results[0].value));
          if (out_data.error !== owed_results[0].error)
            report_mismatch($sformatf("error %0b, expected %0b",
                                      out_data.error, owed_results[0].error));
          void'(owed_results.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Queueing reuses the same beat list for directed and random parts.
  // ---------------------------------------------------------------------------
  task automatic queue_text(string s);
    in_item_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.char_code = s[i];
      b.end_of_expr = (i == s.len() - 1);
      char_queue.push_back(b);
    end
  endtask

  task automatic queue_raw(logic [7:0] c, bit last);
    in_item_t b;
    b.char_code = c;
    b.end_of_expr = last;
    char_queue.push_back(b);
  endtask

  function automatic string rand_number();
    string s = "";
    int unsigned n = ($urandom_range(9) == 0) ? $urandom_range(11, 1) : $urandom_range(2, 1);
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_operator();
    case ($urandom_range(3))
      0: return "+";
      1: return "-";
      2: return "*";
      default: return "/";
    endcase
  endfunction

  // Builds a well-formed expression; depth keeps the stacks mostly in range.
  function automatic string rand_expr(int unsigned depth);
    string s;
    int unsigned terms = $urandom_range(4, 1);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) s = {s, rand_operator()};
      if (depth > 0 && $urandom_range(3) == 0) s = {s, "(", rand_expr(depth - 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  // Queues one random expression: mostly well-formed, some corrupted or noise.
  task automatic queue_random_expr();
    string s = rand_expr(3);
    int unsigned pick = $urandom_range(99);
    if (pick < 10 && s.len() > 1) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
    else if (pick < 15) s = {s, ")"};
    else if (pick < 20) s = {"(", s};
    if (pick >= 20 && pick < 25) begin
      for (int i = 0; i < $urandom_range(6, 1); i++)
        queue_raw(8'($urandom_range(255)), 1'b0);
      queue_raw(8'($urandom_range(255)), 1'b1);
    end else begin
      queue_text(s);
    end
  endtask

  task automatic wait_drained();
    while (char_queue.size() > 0 || in_valid || owed_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    string deep;
    clear_expr();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: operators, precedence, wrap and the error cases but overflow.
    queue_text("1+2*3");
    queue_text("(1+2)*3-4/2");
    queue_text("7/-");                 // unary minus underflows
    queue_text("4294967295");          // literal wraps to -1
    queue_text("7/0");                 // division by zero
    queue_text("0-2147483648/1");      // most negative value
    queue_raw(8'h00, 1'b1);            // code zero is unknown
    queue_raw(8'hFF, 1'b1);
    queue_text("(1)(2)");              // dangling operands
    queue_text("(1+2");                // unmatched open
    queue_text("1+2)");                // unmatched close
    queue_text("1-2-3");
    queue_text("100/7/3*2");
    wait_drained();

    // Stack overflow and the most negative value divided by minus one.
    deep = "";
    for (int i = 0; i < 17; i++) deep = {deep, "("};
    queue_text({deep, "1"});
    queue_text("(0-2147483647-1)/(0-1)");
    // Length limit: characters past the limit are dropped, the flush still counts.
    deep = "1";
    for (int i = 0; i < 70; i++) deep = {deep, "+1"};
    queue_text(deep);

    // Random part in three idling phases, with pressure episodes.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 27 : 0;
      // Long receiver hold-off while the sender keeps going.
      if (ph == 0) hold_off_cycles = 3000;
      while (char_queue.size() < 370 * (ph + 1) / (ph + 1) && char_queue.size() < 380) begin
        queue_random_expr();
      end
      // Part-way through, the sender pauses until every expected result has come.
      while (char_queue.size() > 150) @(posedge clk);
      send_pause = 1'b1;
      while (in_valid || owed_results.size() > 0) @(posedge clk);
      send_pause = 1'b0;
      wait_drained();
    end
    repeat (200) @(posedge clk);
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/iee_pkg.sv
rtl/iee_divider.sv
rtl/iee_datapath.sv
rtl/iee_controller.sv
rtl/infix_expression_evaluator.sv
tb/sv/infix_expression_evaluator_tb.sv
